### design/audio_volume_leveler_defines.svh
// ----------------------------------------------------------------------------
// audio_volume_leveler_defines.svh
// Assertion macros shared by the leveler RTL. Each expects clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef AUDIO_VOLUME_LEVELER_DEFINES_SVH
`define AUDIO_VOLUME_LEVELER_DEFINES_SVH

// same-cycle implication
`define AVL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AVL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/avl_pkg.sv
// ----------------------------------------------------------------------------
// avl_pkg
// Widths, reset values, register indexes and shared types of the leveler.
// ----------------------------------------------------------------------------
package avl_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 25;
    localparam int COEF_W     = 24;
    localparam int TARGET_W   = 23;
    localparam int AMOUNT_W   = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 25;
    localparam int OUT_TDATA_W = 56;
    localparam int ROOT_W     = 32;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 26;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LEVEL   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_COEF    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COEF   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAKEUP_GAIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVELER_AMOUNT = 3'd4;

    // register reset values
    localparam logic [TARGET_W-1:0] TARGET_RST  = 23'd838861;
    localparam logic [COEF_W-1:0]   ATTACK_RST  = 24'd16775468;
    localparam logic [COEF_W-1:0]   RELEASE_RST = 24'd16776866;
    localparam logic [GAIN_W-1:0]   MAKEUP_RST  = 25'd4848350;
    localparam logic [AMOUNT_W-1:0] AMOUNT_RST  = 4'd5;

    localparam logic [GAIN_W-1:0]   ONE_Q20     = 25'd1048576;
    localparam logic [GAIN_W-1:0]   GAIN_MAX    = 25'd33554431;
    localparam logic [SAMPLE_W-1:0] QUIET_FLOOR = 24'd8;

    // request to the ratio / square-root unit
    typedef struct packed {
        logic                start;
        logic [TARGET_W-1:0] target;
        logic [SAMPLE_W-1:0] envelope;
    } avl_root_req_t;

    // status back from the unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } avl_root_stat_t;

    // gain ceiling 1 + 3*amount in Q5.20, saturated
    function automatic logic [GAIN_W-1:0] gain_ceiling(input logic [AMOUNT_W-1:0] amount);
        logic [5:0] steps;
        steps = 6'd1 + 6'(amount) * 6'd3;
        if (steps > 6'd31)
            return GAIN_MAX;
        else
            return {steps[4:0], 20'd0};
    endfunction

endpackage

### design/avl_ratio_root.sv
// ----------------------------------------------------------------------------
// avl_ratio_root
// Iterative floor(sqrt(target * 2^40 / envelope)): radix-2 restoring divide,
// then digit-by-digit square root, two steps per clock in each phase.
// ----------------------------------------------------------------------------
module avl_ratio_root (
    input  logic                  clk,
    input  logic                  rst_n,
    input  avl_pkg::avl_root_req_t  req,
    output avl_pkg::avl_root_stat_t stat
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;

    logic [1:0]  phase_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] num_reg;     // dividend / quotient, then radicand
    logic [23:0] den_reg;
    logic [23:0] drem_reg;
    logic [33:0] srem_reg;
    logic [avl_pkg::ROOT_W-1:0] root_reg;

    // divide: two quotient bits
    logic [24:0] t1, t2;
    logic        q1, q2;
    logic [23:0] r1, r2;

    // square root: two root bits
    logic [35:0] u1, u2, tr1, tr2, v1, v2;
    logic        s1, s2;
    logic [avl_pkg::ROOT_W-1:0] root1, root2;

    always_comb
    begin
        t1 = {drem_reg, num_reg[63]};
        q1 = t1 >= {1'b0, den_reg};
        r1 = q1 ? 24'(t1 - {1'b0, den_reg}) : t1[23:0];
        t2 = {r1, num_reg[62]};
        q2 = t2 >= {1'b0, den_reg};
        r2 = q2 ? 24'(t2 - {1'b0, den_reg}) : t2[23:0];

        u1    = {srem_reg, num_reg[63:62]};
        tr1   = {2'b00, root_reg, 2'b01};
        s1    = u1 >= tr1;
        v1    = s1 ? (u1 - tr1) : u1;
        root1 = {root_reg[avl_pkg::ROOT_W-2:0], s1};
        u2    = {v1[33:0], num_reg[61:60]};
        tr2   = {2'b00, root1, 2'b01};
        s2    = u2 >= tr2;
        v2    = s2 ? (u2 - tr2) : u2;
        root2 = {root1[avl_pkg::ROOT_W-2:0], s2};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                        phase_reg <= PH_DIV;
                end
                PH_DIV:
                begin
                    if (cnt_reg == 5'd0)
                        phase_reg <= PH_SQRT;
                end
                PH_SQRT:
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                    phase_reg <= PH_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    num_reg  <= {1'b0, req.target, 40'd0};
                    den_reg  <= req.envelope;
                    drem_reg <= 24'd0;
                    cnt_reg  <= 5'd31;
                end
            end
            PH_DIV:
            begin
                num_reg  <= {num_reg[61:0], q1, q2};
                drem_reg <= r2;
                if (cnt_reg == 5'd0)
                begin
                    cnt_reg  <= 5'd15;
                    srem_reg <= 34'd0;
                    root_reg <= '0;
                end
                else
                    cnt_reg <= cnt_reg - 5'd1;
            end
            PH_SQRT:
            begin
                num_reg  <= {num_reg[59:0], 4'd0};
                srem_reg <= v2[33:0];
                root_reg <= root2;
                cnt_reg  <= cnt_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.busy = (phase_reg != PH_IDLE);
    assign stat.done = done_reg;
    assign stat.root = root_reg;

endmodule

### design/audio_volume_leveler.sv
// ----------------------------------------------------------------------------
// audio_volume_leveler
// Automatic gain control: envelope follower, sqrt(target/envelope) gain law,
// smoothed gain, saturated Q1.23 output.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Transfer carries
//  --------  -------------------------------  ---------------------------------
//  s_axis    tvalid tready tdata[23:0]        sample_in (Q1.23 signed)
//  m_axis    tvalid tready tdata[55:0]        sample_out, applied_gain
//  cfg       valid ready index[2:0] data[24:0] one register write
//
//  Loud sample: the ratio unit divides, takes the square root and hands the
//  root back, and the shared 33x26 multiplier runs four times. Quiet sample
//  (envelope below the floor): unit skipped, the multiplier runs twice.
//  No new sample is taken while one is in work; a finished result waits in
//  the output register and the next sample is taken meanwhile.
//  Reset: envelope 0, gain 1.0, registers to their defaults. cfg is always
//  ready; writes belong in idle time.
// ----------------------------------------------------------------------------
`include "audio_volume_leveler_defines.svh"

module audio_volume_leveler (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample_in [23:0]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [avl_pkg::SAMPLE_W-1:0]       s_axis_tdata,
    // sample_out [23:0], applied_gain [48:24], zero [55:49]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [avl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [avl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [avl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // sequencer codes
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_ENV_MUL   = 4'd1;
    localparam logic [3:0] ST_ENV_UPD   = 4'd2;
    localparam logic [3:0] ST_ROOT      = 4'd3;
    localparam logic [3:0] ST_WANT_MUL  = 4'd4;
    localparam logic [3:0] ST_WANT_UPD  = 4'd5;
    localparam logic [3:0] ST_GAIN_PREP = 4'd6;
    localparam logic [3:0] ST_GAIN_MUL  = 4'd7;
    localparam logic [3:0] ST_GAIN_UPD  = 4'd8;
    localparam logic [3:0] ST_OUT_MUL   = 4'd9;
    localparam logic [3:0] ST_OUT_UPD   = 4'd10;
    localparam logic [3:0] ST_EMIT      = 4'd11;

    localparam int PW = avl_pkg::PROD_W;
    localparam logic signed [PW-1:0] RND24 = PW'(64'd8388608);
    localparam logic signed [PW-1:0] RND20 = PW'(64'd524288);
    localparam logic signed [PW-1:0] Y_MAX = PW'(64'd8388607);
    localparam logic signed [PW-1:0] Y_MIN = -PW'(64'd8388608);

    // configuration registers
    logic [avl_pkg::TARGET_W-1:0] target_reg;
    logic [avl_pkg::COEF_W-1:0]   attack_reg;
    logic [avl_pkg::COEF_W-1:0]   release_reg;
    logic [avl_pkg::GAIN_W-1:0]   makeup_reg;
    logic [avl_pkg::AMOUNT_W-1:0] amount_reg;

    // control state
    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [avl_pkg::SAMPLE_W-1:0] env_reg, env_next;
    logic [avl_pkg::GAIN_W-1:0]   gain_reg, gain_next;

    // payload
    logic [avl_pkg::SAMPLE_W-1:0] x_reg, x_next;
    logic [avl_pkg::SAMPLE_W-1:0] mag_reg, mag_next;
    logic signed [avl_pkg::MUL_A_W-1:0] a_reg, a_next;
    logic signed [avl_pkg::MUL_B_W-1:0] b_reg, b_next;
    logic signed [PW-1:0]               p_reg;
    logic [avl_pkg::GAIN_W-1:0]   want_reg, want_next;
    logic [avl_pkg::SAMPLE_W-1:0] y_reg, y_next;
    logic [avl_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic [avl_pkg::GAIN_W-1:0]   out_gain_reg, out_gain_next;

    // datapath terms
    logic [avl_pkg::SAMPLE_W-1:0] in_mag;
    logic [avl_pkg::COEF_W-1:0]   in_coef;
    logic signed [PW-1:0]         step24;
    logic signed [PW-1:0]         round20;
    logic [avl_pkg::SAMPLE_W-1:0] env_new;
    logic [avl_pkg::GAIN_W-1:0]   gain_new;
    logic [38:0]                  want_full;
    logic [avl_pkg::GAIN_W-1:0]   ceiling;
    logic [avl_pkg::COEF_W-1:0]   gain_coef;
    logic                         in_xfer;

    avl_pkg::avl_root_req_t  root_req;
    avl_pkg::avl_root_stat_t root_stat;

    avl_ratio_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .stat  (root_stat)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_gain_reg, out_sample_reg};

    // |x|; the most negative code maps to 2^23, which fits unsigned
    assign in_mag  = s_axis_tdata[avl_pkg::SAMPLE_W-1] ? (~s_axis_tdata + 24'd1) : s_axis_tdata;
    assign in_coef = (in_mag > env_reg) ? attack_reg : release_reg;

    // one-pole update: new = input + round(coef * (old - input) / 2^24)
    assign step24    = (p_reg + RND24) >>> 24;
    assign round20   = (p_reg + RND20) >>> 20;
    assign env_new   = mag_reg + step24[avl_pkg::SAMPLE_W-1:0];
    assign gain_new  = want_reg + step24[avl_pkg::GAIN_W-1:0];
    assign want_full = round20[38:0];
    assign ceiling   = avl_pkg::gain_ceiling(amount_reg);
    assign gain_coef = (want_reg < gain_reg) ? attack_reg : release_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        env_next        = env_reg;
        gain_next       = gain_reg;
        x_next          = x_reg;
        mag_next        = mag_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        want_next       = want_reg;
        y_next          = y_reg;
        out_sample_next = out_sample_reg;
        out_gain_next   = out_gain_reg;
        root_req.start    = 1'b0;
        root_req.target   = target_reg;
        root_req.envelope = env_new;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    x_next     = s_axis_tdata;
                    mag_next   = in_mag;
                    a_next     = {9'd0, env_reg} - {9'd0, in_mag};
                    b_next     = {2'b00, in_coef};
                    state_next = ST_ENV_MUL;
                end
            end
            ST_ENV_MUL:
                state_next = ST_ENV_UPD;
            ST_ENV_UPD:
            begin
                env_next = env_new;
                if (env_new >= avl_pkg::QUIET_FLOOR)
                begin
                    root_req.start = 1'b1;
                    state_next     = ST_ROOT;
                end
                else
                begin
                    // quiet: gain held
                    a_next     = {{9{x_reg[avl_pkg::SAMPLE_W-1]}}, x_reg};
                    b_next     = {1'b0, gain_reg};
                    state_next = ST_OUT_MUL;
                end
            end
            ST_ROOT:
            begin
                if (root_stat.done)
                begin
                    a_next     = {1'b0, root_stat.root};
                    b_next     = {1'b0, makeup_reg};
                    state_next = ST_WANT_MUL;
                end
            end
            ST_WANT_MUL:
                state_next = ST_WANT_UPD;
            ST_WANT_UPD:
            begin
                // clamp to [1.0, ceiling]
                if (want_full < {14'd0, avl_pkg::ONE_Q20})
                    want_next = avl_pkg::ONE_Q20;
                else if (want_full > {14'd0, ceiling})
                    want_next = ceiling;
                else
                    want_next = want_full[avl_pkg::GAIN_W-1:0];
                state_next = ST_GAIN_PREP;
            end
            ST_GAIN_PREP:
            begin
                a_next     = {8'd0, gain_reg} - {8'd0, want_reg};
                b_next     = {2'b00, gain_coef};
                state_next = ST_GAIN_MUL;
            end
            ST_GAIN_MUL:
                state_next = ST_GAIN_UPD;
            ST_GAIN_UPD:
            begin
                gain_next  = gain_new;
                a_next     = {{9{x_reg[avl_pkg::SAMPLE_W-1]}}, x_reg};
                b_next     = {1'b0, gain_new};
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL:
                state_next = ST_OUT_UPD;
            ST_OUT_UPD:
            begin
                if (round20 > Y_MAX)
                    y_next = 24'h7FFFFF;
                else if (round20 < Y_MIN)
                    y_next = 24'h800000;
                else
                    y_next = round20[avl_pkg::SAMPLE_W-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // load the output register once it is free or being drained
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = y_reg;
                    out_gain_next   = gain_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            env_reg       <= '0;
            gain_reg      <= avl_pkg::ONE_Q20;
            target_reg    <= avl_pkg::TARGET_RST;
            attack_reg    <= avl_pkg::ATTACK_RST;
            release_reg   <= avl_pkg::RELEASE_RST;
            makeup_reg    <= avl_pkg::MAKEUP_RST;
            amount_reg    <= avl_pkg::AMOUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            env_reg       <= env_next;
            gain_reg      <= gain_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    avl_pkg::REG_TARGET_LEVEL:
                        target_reg <= cfg_data[avl_pkg::TARGET_W-1:0];
                    avl_pkg::REG_ATTACK_COEF:
                        attack_reg <= cfg_data[avl_pkg::COEF_W-1:0];
                    avl_pkg::REG_RELEASE_COEF:
                        release_reg <= cfg_data[avl_pkg::COEF_W-1:0];
                    avl_pkg::REG_MAKEUP_GAIN:
                        makeup_reg <= cfg_data;
                    avl_pkg::REG_LEVELER_AMOUNT:
                        amount_reg <= cfg_data[avl_pkg::AMOUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload and the shared multiplier
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        mag_reg        <= mag_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        p_reg          <= a_reg * b_reg;
        want_reg       <= want_next;
        y_reg          <= y_next;
        out_sample_reg <= out_sample_next;
        out_gain_reg   <= out_gain_next;
    end

    `AVL_ASSERT_IMP(a_gain_floor, 1'b1, gain_reg >= avl_pkg::ONE_Q20, "smoothed gain below unity")
    `AVL_ASSERT_IMP(a_root_alive, state_reg == ST_ROOT, root_stat.busy || root_stat.done, "unit idle")
    `AVL_ASSERT_NXT(a_accept_env, in_xfer, state_reg == ST_ENV_MUL, "transfer not taken up")
    `AVL_ASSERT_IMP(a_out_gain, m_axis_tvalid, out_gain_reg >= avl_pkg::ONE_Q20, "gain below 1")

endmodule

### bench/audio_volume_leveler_tb.sv
// ----------------------------------------------------------------------------
// audio_volume_leveler_tb
// Self-checking bench for the volume leveler. Samples go in on s_axis. Each
// accepted transfer runs through a bit-exact software leveler: envelope
// follower, sqrt gain law, gain smoothing and output saturation. Its result
// is queued and compared with every m_axis transfer. A short directed pass
// at reset settings comes first. Then bursts of loud, quiet and mixed audio
// run under a sweep of register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module audio_volume_leveler_tb;

    import avl_pkg::*;

    typedef longint unsigned u64_t;

    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 7;
    localparam int SETTLE_CYCLES     = 80;
    localparam int STALL_LIMIT       = 5000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES       = 400;   // long m_axis back-pressure
    localparam int PRESSURE_SET      = 2;
    localparam int SETTINGS_N        = 10;
    localparam int ITEMS_PER_SETTING = 193;
    localparam int DIRECTED_N        = 22;
    localparam int SHOW_MAX          = 10;
    localparam int PAD_W             = OUT_TDATA_W - SAMPLE_W - GAIN_W;

    localparam logic [SAMPLE_W-1:0] FULL_POS = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] FULL_NEG = 24'h800000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic [GAIN_W-1:0]   applied_gain;
    } level_result_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                typed;        // result given below, else predicted
        logic [SAMPLE_W-1:0] sample_out;
        logic [GAIN_W-1:0]   applied_gain;
    } stim_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] target;
        logic [CFG_DATA_W-1:0] attack;
        logic [CFG_DATA_W-1:0] rel_coef;
        logic [CFG_DATA_W-1:0] makeup;
        logic [CFG_DATA_W-1:0] amount;
    } reg_set_t;

    typedef enum int {BURST_LOUD, BURST_QUIET, BURST_MIXED} burst_kind_t;

    // Reset settings. While the envelope still rounds to zero, each result is
    // the sample times 1.0.
    localparam stim_row_t DIRECTED [DIRECTED_N] = '{
        '{24'h000000, 1'b1, 24'h000000, ONE_Q20},
        '{24'h000001, 1'b1, 24'h000001, ONE_Q20},
        '{24'hFFFFFF, 1'b1, 24'hFFFFFF, ONE_Q20},
        '{24'h000007, 1'b1, 24'h000007, ONE_Q20},
        '{24'hFFFFF9, 1'b1, 24'hFFFFF9, ONE_Q20},
        '{FULL_POS,   1'b0, '0, '0},
        '{FULL_NEG,   1'b0, '0, '0},
        '{FULL_POS,   1'b0, '0, '0},
        '{FULL_NEG,   1'b0, '0, '0},
        '{24'h000000, 1'b0, '0, '0},
        '{24'h400000, 1'b0, '0, '0},
        '{24'hC00000, 1'b0, '0, '0},
        '{24'h555555, 1'b0, '0, '0},
        '{24'hAAAAAA, 1'b0, '0, '0},
        '{24'h000001, 1'b0, '0, '0},
        '{24'hFFFFFF, 1'b0, '0, '0},
        '{24'h000008, 1'b0, '0, '0},
        '{24'hFFFFF8, 1'b0, '0, '0},
        '{24'h100000, 1'b0, '0, '0},
        '{24'hF00000, 1'b0, '0, '0},
        '{FULL_POS,   1'b0, '0, '0},
        '{24'h000000, 1'b0, '0, '0}
    };

    // Register sweep. The rest are random.
    localparam int FIXED_N = 5;
    localparam reg_set_t FIXED_SETS [FIXED_N] = '{
        // reset values, written back explicitly
        '{25'(TARGET_RST), 25'(ATTACK_RST), 25'(RELEASE_RST), MAKEUP_RST, 25'(AMOUNT_RST)},
        // instant smoothing, biggest gain law, ceiling saturated by amount > 10
        '{25'h07FFFFF, 25'h0000000, 25'h0000000, 25'h1FFFFFF, 25'h000000F},
        // frozen smoothing, zero makeup, ceiling of 1.0
        '{25'h0000001, 25'h0FFFFFF, 25'h0FFFFFF, 25'h0000000, 25'h0000000},
        // high data bits dropped: target becomes zero, amount becomes ten
        '{25'h0800000, 25'h1F00000, 25'h0FFF000, 25'h0100000, 25'h000001A},
        '{25'h00CCCCD, 25'h0800000, 25'h0FF8000, MAKEUP_RST,  25'h000000B}
    };

    localparam int SEND_IDLE  [4] = '{0, 73, 0, 19};
    localparam int RECV_STALL [4] = '{0, 0, 73, 19};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // software copy of the registers and state
    logic [TARGET_W-1:0] tgt_q;
    logic [COEF_W-1:0]   atk_q;
    logic [COEF_W-1:0]   rel_q;
    logic [GAIN_W-1:0]   makeup_q;
    logic [AMOUNT_W-1:0] amount_q;
    logic [SAMPLE_W-1:0] env_q;
    logic [GAIN_W-1:0]   gain_q;

    level_result_t pending_out [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int holds_done     = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int quiet_n        = 0;
    int levelled_n     = 0;
    int mismatches     = 0;
    int idle_run       = 0;

    audio_volume_leveler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // leveler arithmetic
    // ------------------------------------------------------------------------

    // one-pole step in Q0.24, rounded
    function automatic u64_t one_pole(u64_t coef, u64_t old_v, u64_t drive);
        return (coef * old_v + ((u64_t'(1) << 24) - coef) * drive + u64_t'(1 << 23)) >> 24;
    endfunction

    // floor(sqrt(v)) for v below 2^62, one result bit at a time
    function automatic u64_t floor_sqrt(u64_t v);
        u64_t r;
        u64_t cand;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = r | (u64_t'(1) << b);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic level_result_t level_and_scale(logic [SAMPLE_W-1:0] raw);
        longint        x;
        longint        prod;
        longint        y;
        u64_t          mag;
        u64_t          coef;
        u64_t          ratio;
        u64_t          want;
        u64_t          ceil_g;
        u64_t          k;
        level_result_t r;
        x    = longint'($signed(raw));
        mag  = (x < 0) ? u64_t'(-x) : u64_t'(x);
        coef = (mag > u64_t'(env_q)) ? u64_t'(atk_q) : u64_t'(rel_q);
        env_q = SAMPLE_W'(one_pole(coef, env_q, mag));
        // below the floor (zero included) the gain is held
        if (env_q >= QUIET_FLOOR)
        begin
            ratio  = (u64_t'(tgt_q) << 40) / u64_t'(env_q);
            want   = (floor_sqrt(ratio) * u64_t'(makeup_q) + u64_t'(1 << 19)) >> 20;
            ceil_g = (1 + 3 * u64_t'(amount_q)) << 20;
            if (ceil_g > u64_t'(GAIN_MAX))
                ceil_g = GAIN_MAX;
            if (want < u64_t'(ONE_Q20))
                want = ONE_Q20;
            if (want > ceil_g)
                want = ceil_g;
            k = (want < u64_t'(gain_q)) ? u64_t'(atk_q) : u64_t'(rel_q);
            gain_q = GAIN_W'(one_pole(k, gain_q, want));
            levelled_n++;
        end
        else
            quiet_n++;
        prod = x * longint'(gain_q) + 64'sd524288;
        y    = prod >>> 20;
        if (y > 64'sd8388607)
            y = 64'sd8388607;
        else if (y < -64'sd8388608)
            y = -64'sd8388608;
        r.sample_out   = SAMPLE_W'(y);
        r.applied_gain = gain_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    function automatic logic [SAMPLE_W-1:0] pick_sample(burst_kind_t kind);
        int roll;
        roll = $urandom_range(99);
        if (kind == BURST_QUIET || (kind == BURST_MIXED && roll < 35))
        begin
            // hovers around the quiet floor
            if (roll % 4 == 0)
                return '0;
            return SAMPLE_W'(int'($urandom_range(32)) - 16);
        end
        if (roll < 60)
            return SAMPLE_W'($urandom);
        if (roll < 80)
            return SAMPLE_W'($signed(SAMPLE_W'($urandom)) >>> $urandom_range(23));
        case ($urandom_range(3))
            0:       return FULL_POS;
            1:       return FULL_NEG;
            2:       return 24'h000001;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    // One register write; cfg_valid stays high for a following write.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TARGET_LEVEL:   tgt_q    = data[TARGET_W-1:0];
            REG_ATTACK_COEF:    atk_q    = data[COEF_W-1:0];
            REG_RELEASE_COEF:   rel_q    = data[COEF_W-1:0];
            REG_MAKEUP_GAIN:    makeup_q = data[GAIN_W-1:0];
            REG_LEVELER_AMOUNT: amount_q = data[AMOUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(reg_set_t s);
        write_reg(REG_TARGET_LEVEL, s.target);
        write_reg(REG_ATTACK_COEF, s.attack);
        write_reg(REG_RELEASE_COEF, s.rel_coef);
        write_reg(REG_MAKEUP_GAIN, s.makeup);
        write_reg(REG_LEVELER_AMOUNT, s.amount);
        // unmapped indexes must leave everything alone
        for (int i = REG_LEVELER_AMOUNT + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] random_coef();
        // half near 1.0 (slow, realistic), half anywhere
        if ($urandom_range(1) == 0)
            return COEF_W'(24'hFFFFFF - $urandom_range(16'hFFFF));
        return COEF_W'($urandom);
    endfunction

    // Offer one sample; queue its result once the transfer has happened.
    task automatic send_sample(logic [SAMPLE_W-1:0] x, logic typed, level_result_t given);
        level_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = level_and_scale(x);
        pending_out.push_back(typed ? given : predicted);
        samples_sent++;
    endtask

    // results all back, then let the datapath settle
    task automatic drain();
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        reg_set_t    setting;
        burst_kind_t kind;
        int          burst_left;
        stim_row_t   row;
        tgt_q    = TARGET_RST;
        atk_q    = ATTACK_RST;
        rel_q    = RELEASE_RST;
        makeup_q = MAKEUP_RST;
        amount_q = AMOUNT_RST;
        env_q    = '0;
        gain_q   = ONE_Q20;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            row = DIRECTED[i];
            send_sample(row.sample, row.typed,
                        level_result_t'{row.sample_out, row.applied_gain});
        end
        s_axis_tvalid <= 1'b0;
        drain();

        for (int s = 0; s < SETTINGS_N; s++)
        begin
            if (s < FIXED_N)
                setting = FIXED_SETS[s];
            else
            begin
                setting.target   = CFG_DATA_W'($urandom_range(1, 24'h7FFFFF));
                setting.attack   = CFG_DATA_W'(random_coef());
                setting.rel_coef = CFG_DATA_W'(random_coef());
                setting.makeup   = CFG_DATA_W'($urandom);
                setting.amount   = CFG_DATA_W'($urandom_range(15));
            end
            apply_setting(setting);

            send_idle_pct  = SEND_IDLE[s % 4];
            recv_stall_pct = RECV_STALL[s % 4];
            if (s == PRESSURE_SET)
                hold_len = HOLD_CYCLES;

            // bursts of one character so the envelope and gain settle and swing
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                if (burst_left == 0)
                begin
                    kind       = burst_kind_t'($urandom_range(2));
                    burst_left = $urandom_range(8, 40);
                end
                burst_left--;
                send_sample(pick_sample(kind), 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            drain();
        end

        $display("leveler run: %0d samples over %0d register settings and four idling mixes",
                 samples_sent, SETTINGS_N + 1);
        $display("  %0d results checked (%0d held gain, %0d levelled), %0d long hold-offs",
                 results_seen, quiet_n, levelled_n, holds_done);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // m_axis ready: random stalls, or one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                holds_done++;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        level_result_t      want;
        logic [SAMPLE_W-1:0] got_out;
        logic [GAIN_W-1:0]   got_gain;
        logic [PAD_W-1:0]    got_pad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_out  = m_axis_tdata[SAMPLE_W-1:0];
            got_gain = m_axis_tdata[SAMPLE_W +: GAIN_W];
            got_pad  = m_axis_tdata[OUT_TDATA_W-1 -: PAD_W];
            results_seen++;
            if (pending_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("%0t: result with none pending: out %h gain %h",
                             $realtime, got_out, got_gain);
            end
            else
            begin
                want = pending_out.pop_front();
                if (got_out !== want.sample_out || got_gain !== want.applied_gain
                    || got_pad !== '0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("%0t: result %0d: out %h/%h gain %h/%h pad %h (exp/got)",
                                 $realtime, results_seen, want.sample_out, got_out,
                                 want.applied_gain, got_gain, got_pad);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no transfer anywhere for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_out.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
